// ===== rtl/dqsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue with search and reverse.
package dqsr_pkg;

   localparam int DEPTH   = 64;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = PTR_W + 1;
   localparam int MATCH_W = 6;
   localparam int COUNT_W = 7;

   localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
   localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
   localparam logic [3:0] OP_POP_BACK   = 4'd2;
   localparam logic [3:0] OP_POP_FRONT  = 4'd3;
   localparam logic [3:0] OP_PEEK_BACK  = 4'd4;
   localparam logic [3:0] OP_PEEK_FRONT = 4'd5;
   localparam logic [3:0] OP_SEARCH     = 4'd6;
   localparam logic [3:0] OP_REVERSE    = 4'd7;
   localparam logic [3:0] OP_CLEAR      = 4'd8;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_EMPTY     = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [3:0]         operation;
      logic signed [31:0] entry_value;
      logic signed [31:0] entry_weight;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_value;
      logic signed [31:0] out_weight;
      logic [MATCH_W-1:0] match_position;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SEARCH
   } ctrl_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic push;
      logic end_empty;
      logic end_read;
      logic end_finish;
      logic search_miss;
      logic search_init;
      logic search_step;
      logic reverse;
      logic clear;
      logic plain;
   } dqsr_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_push;
      logic is_end;
      logic is_search;
      logic is_reverse;
      logic is_clear;
      logic empty;
      logic search_done;
   } dqsr_stat_type;

endpackage

// ===== rtl/dqsr_dp.sv =====
`timescale 1ns / 1ps
// Datapath: ring store, end pointers, reversal flag, search walk and result register.
module dqsr_dp import dqsr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_item,
   input  dqsr_cmd_type  cmd,
   output dqsr_stat_type stat,
   output logic          rsp_valid,
   output rsp_type       rsp_item
);

   localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);

   function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] t;
      t = (s >= DEPTH_S) ? s - DEPTH_S : s;
      return t[PTR_W-1:0];
   endfunction

   logic [31:0] value_mem  [DEPTH];
   logic [31:0] weight_mem [DEPTH];

   req_type          req_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic             flip_ff, flip_in;
   logic [PTR_W-1:0] cmp_pos_ff, cmp_pos_in;
   logic [PTR_W-1:0] next_pos_ff, next_pos_in;
   logic [31:0]      rd_value_ff, rd_weight_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [3:0]       op;
   logic             end_at_head, push_at_head, is_pop, full, hit, last;
   logic [PTR_W-1:0] tail_slot, push_tail_slot, head_dec, head_inc, end_slot;
   logic [PTR_W-1:0] push_slot, srch_pos, srch_off, srch_slot, rd_addr;
   logic [SUM_W-1:0] occ_s;

   assign op           = req_ff.operation;
   assign occ_s        = SUM_W'(occ_ff);
   assign end_at_head  = (op inside {OP_POP_FRONT, OP_PEEK_FRONT}) ^ flip_ff;
   assign push_at_head = (op == OP_PUSH_FRONT) ^ flip_ff;
   assign is_pop       = (op inside {OP_POP_BACK, OP_POP_FRONT});
   assign full         = (occ_ff == DEPTH_C);

   assign tail_slot      = ring_wrap(SUM_W'(head_ff) + occ_s - SUM_W'(1));
   assign push_tail_slot = ring_wrap(SUM_W'(head_ff) + occ_s);
   assign head_dec       = (head_ff == '0) ? LAST_SLOT : head_ff - PTR_W'(1);
   assign head_inc       = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
   assign end_slot       = end_at_head ? head_ff : tail_slot;
   assign push_slot      = push_at_head ? head_dec : push_tail_slot;

   // Logical position to ring slot; flipped order counts from the physical tail.
   assign srch_pos  = cmd.search_init ? '0 : next_pos_ff;
   assign srch_off  = flip_ff ? PTR_W'(occ_s - SUM_W'(1) - SUM_W'(srch_pos)) : srch_pos;
   assign srch_slot = ring_wrap(SUM_W'(head_ff) + SUM_W'(srch_off));
   assign rd_addr   = cmd.end_read ? end_slot : srch_slot;

   assign hit  = (rd_value_ff == req_ff.entry_value);
   assign last = (SUM_W'(cmp_pos_ff) == occ_s - SUM_W'(1));

   always_comb begin
      stat.is_push     = (op inside {OP_PUSH_BACK, OP_PUSH_FRONT});
      stat.is_end      = (op inside {OP_POP_BACK, OP_POP_FRONT,
                                     OP_PEEK_BACK, OP_PEEK_FRONT});
      stat.is_search   = (op == OP_SEARCH);
      stat.is_reverse  = (op == OP_REVERSE);
      stat.is_clear    = (op == OP_CLEAR);
      stat.empty       = (occ_ff == '0);
      stat.search_done = hit || last;
   end

   always_comb begin
      head_in      = head_ff;
      occ_in       = occ_ff;
      flip_in      = flip_ff;
      cmp_pos_in   = cmp_pos_ff;
      next_pos_in  = next_pos_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status = STS_OK;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
         if (full) begin
            rsp_in.status = STS_FULL;
         end else begin
            occ_in = occ_ff + CNT_W'(1);
            if (push_at_head) begin
               head_in = head_dec;
            end
         end
      end else if (cmd.end_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = STS_EMPTY;
      end else if (cmd.end_finish) begin
         rsp_valid_in      = 1'b1;
         rsp_in.out_value  = rd_value_ff;
         rsp_in.out_weight = rd_weight_ff;
         if (is_pop) begin
            occ_in = occ_ff - CNT_W'(1);
            if (occ_ff == CNT_W'(1)) begin
               head_in = '0;
            end else if (end_at_head) begin
               head_in = head_inc;
            end
         end
      end else if (cmd.search_miss) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = STS_NOT_FOUND;
      end else if (cmd.search_init) begin
         cmp_pos_in  = '0;
         next_pos_in = PTR_W'(1);
      end else if (cmd.search_step) begin
         cmp_pos_in  = next_pos_ff;
         next_pos_in = next_pos_ff + PTR_W'(1);
         if (hit) begin
            rsp_valid_in          = 1'b1;
            rsp_in.match_position = MATCH_W'(cmp_pos_ff);
         end else if (last) begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = STS_NOT_FOUND;
         end
      end else if (cmd.reverse) begin
         rsp_valid_in = 1'b1;
         flip_in      = ~flip_ff;
      end else if (cmd.clear) begin
         rsp_valid_in = 1'b1;
         occ_in       = '0;
         head_in      = '0;
         flip_in      = 1'b0;
      end else if (cmd.plain) begin
         rsp_valid_in = 1'b1;
      end
      rsp_in.entry_count = COUNT_W'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.push && !full) begin
         value_mem[push_slot]  <= req_ff.entry_value;
         weight_mem[push_slot] <= req_ff.entry_weight;
      end
      rd_value_ff  <= value_mem[rd_addr];
      rd_weight_ff <= weight_mem[rd_addr];
      cmp_pos_ff   <= cmp_pos_in;
      next_pos_ff  <= next_pos_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         occ_ff       <= '0;
         flip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         flip_ff      <= flip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_C)
      else $error("occupancy above depth");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (head_ff == '0))
      else $error("empty queue with nonzero head");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

endmodule

// ===== rtl/dqsr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences capture, execute, end read and search walk.
module dqsr_ctrl import dqsr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dqsr_stat_type stat,
   output dqsr_cmd_type  cmd,
   output logic          busy
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (stat.is_push) begin
               cmd.push = 1'b1;
            end else if (stat.is_end) begin
               if (stat.empty) begin
                  cmd.end_empty = 1'b1;
               end else begin
                  cmd.end_read = 1'b1;
                  state_in     = ST_READ;
               end
            end else if (stat.is_search) begin
               if (stat.empty) begin
                  cmd.search_miss = 1'b1;
               end else begin
                  cmd.search_init = 1'b1;
                  state_in        = ST_SEARCH;
               end
            end else if (stat.is_reverse) begin
               cmd.reverse = 1'b1;
            end else if (stat.is_clear) begin
               cmd.clear = 1'b1;
            end else begin
               cmd.plain = 1'b1;
            end
         end
         ST_READ: begin
            cmd.end_finish = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (stat.search_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not reach execute");

   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE))
      else $error("end read did not finish in one cycle");

endmodule

// ===== rtl/deque_with_search_reverse.sv =====
`timescale 1ns / 1ps
// Top level of the double-ended queue with search and reverse.
//
// A bounded double-ended queue of 64 (value, weight) entries held in a ring
// store. A request beat is taken on a rising edge with start high and busy
// low; exactly one result beat follows, shown on rsp_item for a single cycle
// with rsp_valid high, and it cannot be stalled, so sample it when the strobe
// is up. Push, reverse, clear and unused codes finish in the execute state;
// pop and peek add a read state, since the single registered read port of
// the store must return the end entry first (not on an empty queue, where
// nothing is read). A search walks the store through that same read port,
// one entry per cycle, starting at the front, until a match or the last
// entry (an empty queue misses without reading). Reverse only flips which
// physical end is the front, so it moves no data. The result beat appears
// the cycle after the work ends, which is also the first cycle busy is low
// again. Entries are never cleared: only occupied slots are ever read.
module deque_with_search_reverse import dqsr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   dqsr_cmd_type  cmd;
   dqsr_stat_type stat;

   // Sequence each beat through execute, end read or search walk.
   dqsr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Hold the store, pointers and result register; drop nothing, one result per beat.
   dqsr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the double-ended queue with search and reverse.
module tb_top;
   import dqsr_pkg::*;

   // Clock, reset and run-length knobs.
   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_BEATS  = 1500;
   localparam int CALM_FIRST    = 500;   // random beats [CALM_FIRST, CALM_LAST) never idle
   localparam int CALM_LAST     = 900;
   localparam int STALL_LIMIT   = 1000;  // a full-queue search miss is the longest beat
   localparam int SETTLE_CYCLES = 80;
   localparam int PRINT_CAP     = 50;

   // Operation codes the block ignores.
   localparam logic [3:0] OP_UNUSED_LO = 4'd9;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;

   // Traffic shapes for the random part: bias toward filling, draining or a mix.
   typedef enum logic [1:0] {
      MODE_FILL,
      MODE_DRAIN,
      MODE_BALANCED
   } traffic_mode_type;

   // One row of the directed table: the beat, and a typed-in outcome where it
   // is obvious enough to write by hand.
   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type outcome;
   } script_line_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Typed-in outcome that rides along with the beat on the request side.
   bit      typed_check;
   rsp_type typed_result;

   // Shadow copy of the deque: ring store, physical head slot, fill level and
   // the reversal flag that swaps which physical end is the front.
   logic [31:0] shadow_value  [DEPTH];
   logic [31:0] shadow_weight [DEPTH];
   int unsigned head_slot;
   int unsigned fill_level;
   bit          flipped;

   rsp_type         pending_outcomes [$];
   script_line_type directed_script  [$];

   int          mismatches;
   int          beats_in;
   int          beats_out;
   int          stall_cycles;
   int          status_tally [4];

   deque_with_search_reverse u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #HALF_PERIOD clock = ~clock;

   // Ring slot at a physical offset from the head.
   function automatic int unsigned ring_slot(input int unsigned offset);
      return (head_slot + offset) % DEPTH;
   endfunction

   // Apply one beat to the shadow deque and return the result it must produce.
   function automatic rsp_type deque_outcome(input req_type beat);
      rsp_type     r;
      bit          at_head;
      bit          hit;
      int unsigned s;
      int unsigned i;
      int unsigned pos;
      r        = '0;
      r.status = STS_OK;
      hit      = 1'b0;
      pos      = 0;
      case (beat.operation)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (fill_level >= DEPTH) begin
               r.status = STS_FULL;
            end else begin
               // A logical front push lands on the physical tail when reversed.
               at_head = (beat.operation == OP_PUSH_FRONT) ^ flipped;
               if (at_head) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  s = head_slot;
               end else begin
                  s = ring_slot(fill_level);
               end
               shadow_value[s]  = beat.entry_value;
               shadow_weight[s] = beat.entry_weight;
               fill_level++;
            end
         end
         OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
            if (fill_level == 0) begin
               r.status = STS_EMPTY;
            end else begin
               at_head = (beat.operation inside {OP_POP_FRONT, OP_PEEK_FRONT}) ^ flipped;
               s = at_head ? head_slot : ring_slot(fill_level - 1);
               r.out_value  = shadow_value[s];
               r.out_weight = shadow_weight[s];
               if (beat.operation inside {OP_POP_BACK, OP_POP_FRONT}) begin
                  if (at_head) head_slot = (head_slot + 1) % DEPTH;
                  fill_level--;
                  // An emptied queue restarts its ring at slot zero.
                  if (fill_level == 0) head_slot = 0;
               end
            end
         end
         OP_SEARCH: begin
            for (i = 0; i < fill_level && !hit; i++) begin
               s = flipped ? ring_slot(fill_level - 1 - i) : ring_slot(i);
               if (shadow_value[s] == beat.entry_value) begin
                  hit = 1'b1;
                  pos = i;
               end
            end
            r.status         = hit ? STS_OK : STS_NOT_FOUND;
            r.match_position = MATCH_W'(pos);
         end
         OP_REVERSE: begin
            flipped = !flipped;
         end
         OP_CLEAR: begin
            fill_level = 0;
            head_slot  = 0;
            flipped    = 1'b0;
         end
         default: begin
         end
      endcase
      r.entry_count = COUNT_W'(fill_level);
      return r;
   endfunction

   // Value mix: small signed values repeat often so searches see duplicates,
   // the rest are full 32-bit random so every bit toggles.
   function automatic logic [31:0] draw_value();
      if ($urandom_range(0, 99) < 40) return 32'($urandom_range(0, 7)) - 32'd4;
      return $urandom;
   endfunction

   function automatic req_type random_beat(input traffic_mode_type mode);
      req_type    b;
      int         roll;
      logic [3:0] push_op;
      logic [3:0] pop_op;
      logic [3:0] peek_op;
      roll    = $urandom_range(0, 99);
      push_op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      pop_op  = $urandom_range(0, 1) ? OP_POP_FRONT  : OP_POP_BACK;
      peek_op = $urandom_range(0, 1) ? OP_PEEK_FRONT : OP_PEEK_BACK;
      b.entry_value  = draw_value();
      b.entry_weight = $urandom;
      case (mode)
         MODE_FILL: begin
            b.operation = roll < 72 ? push_op : roll < 78 ? pop_op :
                          roll < 84 ? peek_op : roll < 96 ? OP_SEARCH : OP_REVERSE;
         end
         MODE_DRAIN: begin
            b.operation = roll < 10 ? push_op : roll < 70 ? pop_op :
                          roll < 80 ? peek_op : roll < 94 ? OP_SEARCH : OP_REVERSE;
         end
         default: begin
            b.operation = roll < 30 ? push_op : roll < 58 ? pop_op :
                          roll < 72 ? peek_op : roll < 90 ? OP_SEARCH :
                          roll < 95 ? OP_REVERSE : roll < 97 ? OP_CLEAR :
                          4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end
      endcase
      // Aim most searches at a value that is really held.
      if (b.operation == OP_SEARCH && fill_level != 0 && $urandom_range(0, 99) < 60)
         b.entry_value = shadow_value[ring_slot($urandom_range(0, fill_level - 1))];
      return b;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("[%0t] result beat %0d: %s", $time, beats_out, what);
   endtask

   task automatic add_line(input logic [3:0] op, input logic [31:0] v, input logic [31:0] w,
                           input bit typed, input logic [1:0] sts, input logic [31:0] ov,
                           input logic [31:0] ow, input logic [5:0] pos,
                           input logic [6:0] cnt);
      script_line_type l;
      l.beat.operation          = op;
      l.beat.entry_value        = v;
      l.beat.entry_weight       = w;
      l.typed                   = typed;
      l.outcome.status          = sts;
      l.outcome.out_value       = ov;
      l.outcome.out_weight      = ow;
      l.outcome.match_position  = pos;
      l.outcome.entry_count     = cnt;
      directed_script.push_back(l);
   endtask

   // Present one beat from a falling edge and hold it until the block takes it.
   // Returns at the falling edge after the accepting rising edge.
   task automatic send_beat(input req_type beat, input bit typed, input rsp_type outcome,
                            input bit may_idle);
      int unsigned gap;
      if (may_idle && $urandom_range(0, 99) < 10) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        <= 1'b1;
      req_item     <= beat;
      typed_check  <= typed;
      typed_result <= outcome;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Scoreboard: check the result strobe first, since a beat accepted on the
   // same edge cannot have produced it, then predict any newly accepted beat.
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (rsp_valid) begin
            beats_out++;
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("unexpected result, status %0d count %0d",
                                         rsp_item.status, rsp_item.entry_count));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_item.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_item.status, want.status));
               if (rsp_item.out_value !== want.out_value)
                  report_mismatch($sformatf("out_value got %h want %h",
                                            rsp_item.out_value, want.out_value));
               if (rsp_item.out_weight !== want.out_weight)
                  report_mismatch($sformatf("out_weight got %h want %h",
                                            rsp_item.out_weight, want.out_weight));
               if (rsp_item.match_position !== want.match_position)
                  report_mismatch($sformatf("match_position got %0d want %0d",
                                            rsp_item.match_position, want.match_position));
               if (rsp_item.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                                            rsp_item.entry_count, want.entry_count));
            end
         end
         if (start && !busy) begin
            // Always advance the shadow state; a typed-in row overrides the prediction.
            want = deque_outcome(req_item);
            if (typed_check) want = typed_result;
            status_tally[want.status]++;
            pending_outcomes.push_back(want);
            beats_in++;
         end
         if (rsp_valid || (start && !busy)) stall_cycles = 0;
         else stall_cycles++;
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(negedge clock);
      $display("[%0t] no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      traffic_mode_type mode;
      int               mode_left;
      int               n;
      mismatches   = 0;
      beats_in     = 0;
      beats_out    = 0;
      stall_cycles = 0;
      head_slot    = 0;
      fill_level   = 0;
      flipped      = 1'b0;
      typed_check  = 1'b0;
      typed_result = '0;
      start        = 1'b0;
      req_item     = '0;
      reset        = 1'b1;
      mode         = MODE_BALANCED;
      mode_left    = 0;

      // Directed table. Empty-queue ends, reverse and clear on empty, the
      // front-push and single-entry pop repairs, signed extremes, peeks and
      // searches across a reversal, unused codes, then a final clear.
      add_line(OP_POP_BACK,   0, 0, 1, STS_EMPTY, 0, 0, 0, 0);
      add_line(OP_POP_FRONT,  0, 0, 1, STS_EMPTY, 0, 0, 0, 0);
      add_line(OP_PEEK_BACK,  0, 0, 1, STS_EMPTY, 0, 0, 0, 0);
      add_line(OP_PEEK_FRONT, 0, 0, 1, STS_EMPTY, 0, 0, 0, 0);
      add_line(OP_SEARCH,     0, 0, 1, STS_NOT_FOUND, 0, 0, 0, 0);
      add_line(OP_REVERSE,    0, 0, 1, STS_OK, 0, 0, 0, 0);
      add_line(OP_CLEAR,      0, 0, 1, STS_OK, 0, 0, 0, 0);
      add_line(OP_PUSH_FRONT, 32'h7FFF_FFFF, 32'h8000_0000, 1, STS_OK, 0, 0, 0, 1);
      add_line(OP_POP_FRONT,  0, 0, 1, STS_OK, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      add_line(OP_PUSH_BACK,  32'h8000_0000, 32'h7FFF_FFFF, 1, STS_OK, 0, 0, 0, 1);
      add_line(OP_PUSH_FRONT, 32'hFFFF_FFFF, 32'h0000_0000, 1, STS_OK, 0, 0, 0, 2);
      add_line(OP_PUSH_BACK,  32'h0000_0000, 32'hFFFF_FFFF, 1, STS_OK, 0, 0, 0, 3);
      add_line(OP_PEEK_FRONT, 0, 0, 1, STS_OK, 32'hFFFF_FFFF, 32'h0000_0000, 0, 3);
      add_line(OP_PEEK_BACK,  0, 0, 1, STS_OK, 32'h0000_0000, 32'hFFFF_FFFF, 0, 3);
      add_line(OP_SEARCH,     32'h8000_0000, 0, 1, STS_OK, 0, 0, 1, 3);
      add_line(OP_REVERSE,    0, 0, 1, STS_OK, 0, 0, 0, 3);
      add_line(OP_SEARCH,     32'h0000_0000, 0, 1, STS_OK, 0, 0, 0, 3);
      add_line(OP_SEARCH,     32'd12345, 0, 1, STS_NOT_FOUND, 0, 0, 0, 3);
      add_line(OP_PUSH_FRONT, 32'd5, 32'd6, 0, STS_OK, 0, 0, 0, 0);
      add_line(OP_POP_BACK,   0, 0, 0, STS_OK, 0, 0, 0, 0);
      add_line(OP_UNUSED_LO,  $urandom, $urandom, 0, STS_OK, 0, 0, 0, 0);
      add_line(OP_UNUSED_HI,  $urandom, $urandom, 0, STS_OK, 0, 0, 0, 0);
      add_line(OP_PEEK_BACK,  0, 0, 0, STS_OK, 0, 0, 0, 0);
      add_line(OP_POP_FRONT,  0, 0, 0, STS_OK, 0, 0, 0, 0);
      add_line(OP_CLEAR,      0, 0, 1, STS_OK, 0, 0, 0, 0);

      // Hold reset, then release it on a falling edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_script[k])
         send_beat(directed_script[k].beat, directed_script[k].typed,
                   directed_script[k].outcome, 1'b1);

      // Random part: switch traffic shape every few dozen beats so the queue
      // swings between full and empty; one long stretch runs with no idling.
      for (n = 0; n < RANDOM_BEATS; n++) begin
         if (mode_left == 0) begin
            mode      = traffic_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(40, 120);
         end
         mode_left--;
         send_beat(random_beat(mode), 1'b0, '0, !(n >= CALM_FIRST && n < CALM_LAST));
      end
      start <= 1'b0;

      // Drain: wait for every outstanding result, then watch for strays.
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_outcomes.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));

      $display("Run covered %0d request beats and %0d result beats.", beats_in, beats_out);
      $display("Outcomes: %0d ok, %0d empty, %0d full, %0d not found.",
               status_tally[STS_OK], status_tally[STS_EMPTY],
               status_tally[STS_FULL], status_tally[STS_NOT_FOUND]);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/dqsr_pkg.sv
rtl/dqsr_dp.sv
rtl/dqsr_ctrl.sv
rtl/deque_with_search_reverse.sv
bench/tb_top.sv
